FILE: sv/mlcf_pkg.sv
package mlcf_pkg;

    // message codes
    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_STORE = 3'd1;
    localparam logic [2:0] OP_GETS  = 3'd2;
    localparam logic [2:0] OP_GETM  = 3'd3;
    localparam logic [2:0] OP_DATA  = 3'd4;

    // encoded line state as seen on the result word
    localparam logic [3:0] CODE_I   = 4'd0;
    localparam logic [3:0] CODE_S   = 4'd1;
    localparam logic [3:0] CODE_E   = 4'd2;
    localparam logic [3:0] CODE_O   = 4'd3;
    localparam logic [3:0] CODE_M   = 4'd4;
    localparam logic [3:0] CODE_F   = 4'd5;
    localparam logic [3:0] CODE_IS  = 4'd6;
    localparam logic [3:0] CODE_IM  = 4'd7;
    localparam logic [3:0] CODE_SM  = 4'd8;
    localparam logic [3:0] CODE_OM  = 4'd9;
    localparam logic [3:0] CODE_OOM = 4'd10;
    localparam logic [3:0] CODE_FM  = 4'd11;
    localparam logic [3:0] CODE_FFM = 4'd12;

    typedef enum logic [12:0] {
        ST_I   = 13'b0_0000_0000_0001,
        ST_S   = 13'b0_0000_0000_0010,
        ST_E   = 13'b0_0000_0000_0100,
        ST_O   = 13'b0_0000_0000_1000,
        ST_M   = 13'b0_0000_0001_0000,
        ST_F   = 13'b0_0000_0010_0000,
        ST_IS  = 13'b0_0000_0100_0000,
        ST_IM  = 13'b0_0000_1000_0000,
        ST_SM  = 13'b0_0001_0000_0000,
        ST_OM  = 13'b0_0010_0000_0000,
        ST_OOM = 13'b0_0100_0000_0000,
        ST_FM  = 13'b0_1000_0000_0000,
        ST_FFM = 13'b1_0000_0000_0000
    } t_line_state;

    typedef struct packed {
        logic gets;
        logic getm;
        logic cpu;
        logic supply;
        logic shared;
        logic miss;
        logic upgrade;
        logic err;
    } t_pulses;

    function automatic logic [3:0] state_code(input t_line_state st);
        logic [3:0] code;
        case (st)
            ST_I:    code = CODE_I;
            ST_S:    code = CODE_S;
            ST_E:    code = CODE_E;
            ST_O:    code = CODE_O;
            ST_M:    code = CODE_M;
            ST_F:    code = CODE_F;
            ST_IS:   code = CODE_IS;
            ST_IM:   code = CODE_IM;
            ST_SM:   code = CODE_SM;
            ST_OM:   code = CODE_OM;
            ST_OOM:  code = CODE_OOM;
            ST_FM:   code = CODE_FM;
            ST_FFM:  code = CODE_FFM;
            default: code = CODE_I;
        endcase
        return code;
    endfunction

endpackage

FILE: sv/mlcf_in_if.sv
interface mlcf_in_if #(
    parameter int NODE_ID_BITS = 4,
    parameter int ADDR_BITS    = 32
);
    logic                    valid;
    logic                    ready;
    logic [2:0]              opcode;
    logic [ADDR_BITS-1:0]    req_addr;
    logic [NODE_ID_BITS-1:0] requester_id;
    logic                    shared_sampled;

    modport source (
        output valid, opcode, req_addr, requester_id, shared_sampled,
        input  ready
    );
    modport sink (
        input  valid, opcode, req_addr, requester_id, shared_sampled,
        output ready
    );
endinterface

FILE: sv/mlcf_out_if.sv
interface mlcf_out_if #(
    parameter int NODE_ID_BITS = 4,
    parameter int ADDR_BITS    = 32
);
    logic                    valid;
    logic                    ready;
    logic                    issue_gets;
    logic                    issue_getm;
    logic                    data_to_cpu;
    logic                    supply_on_bus;
    logic [NODE_ID_BITS-1:0] supply_dest;
    logic                    assert_shared;
    logic [ADDR_BITS-1:0]    out_addr;
    logic                    miss_pulse;
    logic                    upgrade_pulse;
    logic                    protocol_error;
    logic [3:0]              new_state;

    modport source (
        output valid, issue_gets, issue_getm, data_to_cpu, supply_on_bus, supply_dest,
               assert_shared, out_addr, miss_pulse, upgrade_pulse, protocol_error,
               new_state,
        input  ready
    );
    modport sink (
        input  valid, issue_gets, issue_getm, data_to_cpu, supply_on_bus, supply_dest,
               assert_shared, out_addr, miss_pulse, upgrade_pulse, protocol_error,
               new_state,
        output ready
    );
endinterface

FILE: sv/mlcf_decode.sv
module mlcf_decode (
    input  mlcf_pkg::t_line_state i_state,
    input  logic [2:0]            i_opcode,
    input  logic                  i_shared,
    output mlcf_pkg::t_pulses     o_pulses,
    output mlcf_pkg::t_line_state o_next_state
);
    import mlcf_pkg::*;

    t_pulses     p;
    t_line_state ns;
    logic        is_load;
    logic        is_gets;
    logic        is_getm;
    logic        is_data;

    assign is_load = (i_opcode == OP_LOAD);
    assign is_gets = (i_opcode == OP_GETS);
    assign is_getm = (i_opcode == OP_GETM);
    assign is_data = (i_opcode == OP_DATA);

    always_comb begin
        p  = '0;
        ns = i_state;
        if (i_opcode inside {OP_LOAD, OP_STORE}) begin
            case (i_state)
                ST_I: begin
                    p.miss = 1'b1;
                    if (is_load) begin
                        p.gets = 1'b1;
                        ns     = ST_IS;
                    end else begin
                        p.getm = 1'b1;
                        ns     = ST_IM;
                    end
                end
                ST_S, ST_O, ST_F: begin
                    if (is_load) begin
                        p.cpu = 1'b1;
                    end else begin
                        p.getm = 1'b1;
                        p.miss = 1'b1;
                        ns     = (i_state == ST_S) ? ST_SM :
                                 (i_state == ST_O) ? ST_OM : ST_FM;
                    end
                end
                ST_E: begin
                    p.cpu = 1'b1;
                    if (!is_load) begin
                        p.upgrade = 1'b1;
                        ns        = ST_M;
                    end
                end
                ST_M: begin
                    p.cpu = 1'b1;
                end
                // processor request while a transaction is in flight
                default: begin
                    p.err = 1'b1;
                end
            endcase
        end else if (i_opcode inside {OP_GETS, OP_GETM, OP_DATA}) begin
            case (i_state)
                ST_I: begin
                end
                ST_S: begin
                    if (is_gets) begin
                        p.shared = 1'b1;
                    end else if (is_getm) begin
                        ns = ST_I;
                    end
                end
                ST_E: begin
                    if (is_gets) begin
                        p.shared = 1'b1;
                        p.supply = 1'b1;
                        ns       = ST_F;
                    end else if (is_getm) begin
                        p.supply = 1'b1;
                        ns       = ST_I;
                    end
                end
                ST_O, ST_F: begin
                    if (is_gets) begin
                        p.shared = 1'b1;
                        p.supply = 1'b1;
                    end else if (is_getm) begin
                        p.supply = 1'b1;
                        ns       = ST_I;
                    end
                end
                ST_M: begin
                    if (is_gets) begin
                        p.shared = 1'b1;
                        p.supply = 1'b1;
                        ns       = ST_O;
                    end else if (is_getm) begin
                        p.supply = 1'b1;
                        ns       = ST_I;
                    end
                end
                ST_IS: begin
                    if (is_data) begin
                        p.cpu = 1'b1;
                        ns    = i_shared ? ST_S : ST_E;
                    end
                end
                ST_IM: begin
                    if (is_data) begin
                        p.cpu = 1'b1;
                        ns    = ST_M;
                    end
                end
                ST_SM, ST_OOM, ST_FFM: begin
                    if (is_data) begin
                        p.cpu = 1'b1;
                        ns    = ST_M;
                    end else begin
                        p.shared = 1'b1;
                    end
                end
                ST_OM, ST_FM: begin
                    if (is_data) begin
                        p.cpu = 1'b1;
                        ns    = ST_M;
                    end else begin
                        // still the owner until our own data arrives
                        p.shared = 1'b1;
                        p.supply = 1'b1;
                        if (is_getm) begin
                            ns = (i_state == ST_OM) ? ST_OOM : ST_FFM;
                        end
                    end
                end
                default: begin
                    p.err = 1'b1;
                end
            endcase
        end else begin
            p.err = 1'b1;
        end

        if (p.err) begin
            p     = '0;
            p.err = 1'b1;
            ns    = i_state;
        end
    end

    assign o_pulses     = p;
    assign o_next_state = ns;

endmodule

FILE: sv/moesif_line_coherence_fsm.sv
// channel | modport           | word
// --------+-------------------+---------------------------------------------------
// i_in    | mlcf_in_if.sink   | opcode, req_addr, requester_id, shared_sampled
// o_out   | mlcf_out_if.source| bus/cpu pulses, supply_dest, out_addr, events, state
//
// one result word per input word, one word per cycle sustained while o_out.ready
// does not stall; each word passes the input register and the result register around the decode.
// the line state updates when a word moves from the input register to the result
// register, so back-to-back words see each other's state.
// i_rst_n (synchronous, active low) empties both registers and puts the line in I.
// a stalled result register holds the input register, which then holds i_in.ready low.
module moesif_line_coherence_fsm #(
    parameter int NODE_ID_BITS = 4,
    parameter int ADDR_BITS    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mlcf_in_if.sink           i_in,
    mlcf_out_if.source        o_out
);
    import mlcf_pkg::*;

    // input register
    logic                    r_in_valid;
    logic [2:0]              r_opcode;
    logic [ADDR_BITS-1:0]    r_addr;
    logic [NODE_ID_BITS-1:0] r_req_id;
    logic                    r_shared;

    // line state
    t_line_state             r_state;

    // result register
    logic                    r_out_valid;
    t_pulses                 r_pulses;
    logic [NODE_ID_BITS-1:0] r_dest;
    logic [ADDR_BITS-1:0]    r_out_addr;
    logic [3:0]              r_state_code;

    t_pulses                 n_pulses;
    t_line_state             n_state;
    logic                    out_free;
    logic                    advance;
    logic                    addr_used;

    mlcf_decode u_decode (
        .i_state      (r_state),
        .i_opcode     (r_opcode),
        .i_shared     (r_shared),
        .o_pulses     (n_pulses),
        .o_next_state (n_state)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign addr_used  = n_pulses.gets || n_pulses.getm || n_pulses.cpu || n_pulses.supply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_opcode <= i_in.opcode;
            r_addr   <= i_in.req_addr;
            r_req_id <= i_in.requester_id;
            r_shared <= i_in.shared_sampled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_I;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pulses     <= n_pulses;
            r_dest       <= n_pulses.supply ? r_req_id : '0;
            r_out_addr   <= addr_used ? r_addr : '0;
            r_state_code <= state_code(n_state);
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.issue_gets     = r_pulses.gets;
    assign o_out.issue_getm     = r_pulses.getm;
    assign o_out.data_to_cpu    = r_pulses.cpu;
    assign o_out.supply_on_bus  = r_pulses.supply;
    assign o_out.supply_dest    = r_dest;
    assign o_out.assert_shared  = r_pulses.shared;
    assign o_out.out_addr       = r_out_addr;
    assign o_out.miss_pulse     = r_pulses.miss;
    assign o_out.upgrade_pulse  = r_pulses.upgrade;
    assign o_out.protocol_error = r_pulses.err;
    assign o_out.new_state      = r_state_code;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import mlcf_pkg::*;

    localparam int ADDR_W        = 32;
    localparam int NODE_W        = 4;
    localparam int RAND_WORDS    = 680;
    localparam int SINK_HOLD_CYC = 50;

    // opcodes the block must reject
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic              gets;
        logic              getm;
        logic              cpu;
        logic              supply;
        logic [NODE_W-1:0] dest;
        logic              shared;
        logic [ADDR_W-1:0] addr;
        logic              miss;
        logic              upgrade;
        logic              err;
        logic [3:0]        state;
    } t_line_resp;

    typedef struct packed {
        logic [2:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [NODE_W-1:0] id;
        logic              sh;
        logic              typed;
        t_line_resp        gold;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mlcf_in_if  #(.NODE_ID_BITS(NODE_W), .ADDR_BITS(ADDR_W)) in_if ();
    mlcf_out_if #(.NODE_ID_BITS(NODE_W), .ADDR_BITS(ADDR_W)) out_if ();

    moesif_line_coherence_fsm #(
        .NODE_ID_BITS (NODE_W),
        .ADDR_BITS    (ADDR_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("[moesif_line_coherence_fsm] ERROR");
        $finish;
    end

    logic [3:0]  line_st;
    t_line_resp  pending_resp[$];
    t_stim_row   dir_tbl[$];
    int          n_bad = 0;
    int          src_idle_pct = 0;
    int          hold_reqs = 0;

    function automatic int pause_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    // next line state and bus/cpu pulses for one message
    function automatic t_line_resp coherence_step(input logic [2:0] op,
                                                  input logic [ADDR_W-1:0] a,
                                                  input logic [NODE_W-1:0] id,
                                                  input logic sh);
        t_line_resp r;
        logic [3:0] nxt;
        logic       is_ld;
        logic       is_gets;
        logic       is_getm;
        logic       is_data;
        r       = '0;
        nxt     = line_st;
        is_ld   = (op == OP_LOAD);
        is_gets = (op == OP_GETS);
        is_getm = (op == OP_GETM);
        is_data = (op == OP_DATA);
        if (op == OP_LOAD || op == OP_STORE) begin
            case (line_st)
                CODE_I: begin
                    r.gets = is_ld;
                    r.getm = !is_ld;
                    r.miss = 1'b1;
                    nxt    = is_ld ? CODE_IS : CODE_IM;
                end
                CODE_S, CODE_O, CODE_F: begin
                    if (is_ld) begin
                        r.cpu = 1'b1;
                    end else begin
                        r.getm = 1'b1;
                        r.miss = 1'b1;
                        nxt = (line_st == CODE_S) ? CODE_SM :
                              (line_st == CODE_O) ? CODE_OM : CODE_FM;
                    end
                end
                CODE_E: begin
                    r.cpu = 1'b1;
                    if (!is_ld) begin
                        nxt       = CODE_M;
                        r.upgrade = 1'b1;
                    end
                end
                CODE_M: r.cpu = 1'b1;
                default: r.err = 1'b1;
            endcase
        end else if (is_gets || is_getm || is_data) begin
            case (line_st)
                CODE_I: r.err = 1'b0;
                CODE_S: begin
                    if (is_gets) r.shared = 1'b1;
                    else if (is_getm) nxt = CODE_I;
                end
                CODE_E: begin
                    if (is_gets) begin
                        r.shared = 1'b1;
                        r.supply = 1'b1;
                        nxt      = CODE_F;
                    end else if (is_getm) begin
                        r.supply = 1'b1;
                        nxt      = CODE_I;
                    end
                end
                CODE_O, CODE_F: begin
                    if (is_gets) begin
                        r.shared = 1'b1;
                        r.supply = 1'b1;
                    end else if (is_getm) begin
                        r.supply = 1'b1;
                        nxt      = CODE_I;
                    end
                end
                CODE_M: begin
                    if (is_gets) begin
                        r.shared = 1'b1;
                        r.supply = 1'b1;
                        nxt      = CODE_O;
                    end else if (is_getm) begin
                        r.supply = 1'b1;
                        nxt      = CODE_I;
                    end
                end
                CODE_IS: begin
                    if (is_data) begin
                        r.cpu = 1'b1;
                        nxt   = sh ? CODE_S : CODE_E;
                    end
                end
                CODE_IM: begin
                    if (is_data) begin
                        r.cpu = 1'b1;
                        nxt   = CODE_M;
                    end
                end
                CODE_SM, CODE_OOM, CODE_FFM: begin
                    if (is_data) begin
                        r.cpu = 1'b1;
                        nxt   = CODE_M;
                    end else begin
                        r.shared = 1'b1;
                    end
                end
                CODE_OM, CODE_FM: begin
                    if (is_data) begin
                        r.cpu = 1'b1;
                        nxt   = CODE_M;
                    end else begin
                        r.shared = 1'b1;
                        r.supply = 1'b1;
                        if (is_getm) nxt = (line_st == CODE_OM) ? CODE_OOM : CODE_FFM;
                    end
                end
                default: r.err = 1'b1;
            endcase
        end else begin
            r.err = 1'b1;
        end
        // an illegal message drops every pulse and keeps the state
        if (r.err) begin
            r     = '0;
            r.err = 1'b1;
            nxt   = line_st;
        end
        line_st = nxt;
        if (r.supply) r.dest = id;
        if (r.gets || r.getm || r.cpu || r.supply) r.addr = a;
        r.state = nxt;
        return r;
    endfunction

    function automatic t_line_resp gold_resp(input logic [3:0] st, input logic e,
                                             input logic gt, input logic ms,
                                             input logic [ADDR_W-1:0] a);
        t_line_resp r;
        r       = '0;
        r.state = st;
        r.err   = e;
        r.gets  = gt;
        r.miss  = ms;
        r.addr  = a;
        return r;
    endfunction

    task automatic add_row(input logic [2:0] op, input logic [ADDR_W-1:0] a,
                           input logic [NODE_W-1:0] id, input logic sh,
                           input logic typed, input t_line_resp gold);
        t_stim_row r;
        r.op    = op;
        r.addr  = a;
        r.id    = id;
        r.sh    = sh;
        r.typed = typed;
        r.gold  = gold;
        dir_tbl.push_back(r);
    endtask

    // mostly well-formed traffic: misses get their data, stable lines see snoops
    task automatic pick_word(output t_stim_row r);
        int   roll;
        logic transient;
        roll      = $urandom_range(0, 99);
        transient = (line_st >= CODE_IS);
        r.typed   = 1'b0;
        r.gold    = '0;
        r.id      = NODE_W'($urandom_range(0, 15));
        r.sh      = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0: r.addr = '0;
            1: r.addr = '1;
            default: r.addr = $urandom;
        endcase
        if (roll < 8) begin
            r.op = 3'($urandom_range(0, 7));
        end else if (transient) begin
            if (roll < 55) r.op = OP_DATA;
            else if (roll < 90) r.op = roll[0] ? OP_GETS : OP_GETM;
            else r.op = roll[0] ? OP_LOAD : OP_STORE;
        end else begin
            if (roll < 55) r.op = roll[0] ? OP_LOAD : OP_STORE;
            else if (roll < 95) r.op = roll[0] ? OP_GETS : OP_GETM;
            else r.op = OP_DATA;
        end
    endtask

    task automatic send_word(input t_stim_row r);
        t_line_resp want;
        in_if.valid          <= 1'b1;
        in_if.opcode         <= r.op;
        in_if.req_addr       <= r.addr;
        in_if.requester_id   <= r.id;
        in_if.shared_sampled <= r.sh;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        want = coherence_step(r.op, r.addr, r.id, r.sh);
        if (r.typed) want = r.gold;
        pending_resp.push_back(want);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            repeat (pause_len()) @(posedge i_clk);
        end
    endtask

    // result side: random stalls plus a long hold-off on request
    int sink_wait;
    int sink_cyc;
    int sink_idle_pct;
    int hold_seen;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready  <= 1'b0;
            sink_wait     <= 0;
            sink_cyc      <= 0;
            sink_idle_pct <= 15;
            hold_seen     <= 0;
        end else begin
            sink_cyc <= sink_cyc + 1;
            if (sink_cyc % 256 == 255) sink_idle_pct <= pick_idle_pct();
            if (hold_seen != hold_reqs) begin
                hold_seen    <= hold_reqs;
                sink_wait    <= SINK_HOLD_CYC - 1;
                out_if.ready <= 1'b0;
            end else if (sink_wait != 0) begin
                sink_wait    <= sink_wait - 1;
                out_if.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < sink_idle_pct) begin
                sink_wait    <= pause_len() - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // capture at the edge, compare at the following falling edge once the request side has pushed
    logic       out_fire = 1'b0;
    t_line_resp out_word;
    t_line_resp due;

    always @(posedge i_clk) begin
        out_fire <= i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1;
        out_word <= {out_if.issue_gets, out_if.issue_getm, out_if.data_to_cpu,
                     out_if.supply_on_bus, out_if.supply_dest, out_if.assert_shared,
                     out_if.out_addr, out_if.miss_pulse, out_if.upgrade_pulse,
                     out_if.protocol_error, out_if.new_state};
    end

    task automatic cmp_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
            n_bad++;
        end
    endtask

    always @(negedge i_clk) begin
        if (out_fire) begin
            if (pending_resp.size() == 0) begin
                $display("%0t: result word with nothing pending, expected none, actual %h",
                         $time, out_word);
                n_bad++;
            end else begin
                due = pending_resp.pop_front();
                cmp_field("issue_gets", due.gets, out_word.gets);
                cmp_field("issue_getm", due.getm, out_word.getm);
                cmp_field("data_to_cpu", due.cpu, out_word.cpu);
                cmp_field("supply_on_bus", due.supply, out_word.supply);
                cmp_field("supply_dest", due.dest, out_word.dest);
                cmp_field("assert_shared", due.shared, out_word.shared);
                cmp_field("out_addr", due.addr, out_word.addr);
                cmp_field("miss_pulse", due.miss, out_word.miss);
                cmp_field("upgrade_pulse", due.upgrade, out_word.upgrade);
                cmp_field("protocol_error", due.err, out_word.err);
                cmp_field("new_state", due.state, out_word.state);
            end
        end
    end

    initial begin
        t_stim_row r;
        i_rst_n              <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.opcode         <= OP_LOAD;
        in_if.req_addr       <= '0;
        in_if.requester_id   <= '0;
        in_if.shared_sampled <= 1'b0;
        line_st = CODE_I;

        // walk through most stable and transient states
        add_row(OP_GETS,  32'hFFFF_FFFF, 4'hF, 1'b1, 1'b1,
                gold_resp(CODE_I, 1'b0, 1'b0, 1'b0, 32'h0));
        add_row(OP_LOAD,  32'hFFFF_FFFF, 4'hF, 1'b1, 1'b1,
                gold_resp(CODE_IS, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF));
        add_row(OP_STORE, 32'h1234_5678, 4'h3, 1'b0, 1'b1,
                gold_resp(CODE_IS, 1'b1, 1'b0, 1'b0, 32'h0));
        add_row(OP_RSVD5, 32'hFFFF_FFFF, 4'hF, 1'b1, 1'b1,
                gold_resp(CODE_IS, 1'b1, 1'b0, 1'b0, 32'h0));
        add_row(OP_DATA,  32'h0000_0000, 4'h0, 1'b0, 1'b0, '0);
        add_row(OP_STORE, 32'hA5A5_5A5A, 4'h5, 1'b0, 1'b0, '0);
        add_row(OP_GETS,  32'hFFFF_FFFF, 4'hF, 1'b1, 1'b0, '0);
        add_row(OP_STORE, 32'h8000_0001, 4'h8, 1'b0, 1'b0, '0);
        add_row(OP_GETM,  32'h0000_0000, 4'h0, 1'b0, 1'b0, '0);
        add_row(OP_LOAD,  32'h7FFF_FFFE, 4'h1, 1'b1, 1'b1,
                gold_resp(CODE_OOM, 1'b1, 1'b0, 1'b0, 32'h0));
        add_row(OP_DATA,  32'h5555_AAAA, 4'h2, 1'b0, 1'b0, '0);
        add_row(OP_GETM,  32'hDEAD_BEEF, 4'hA, 1'b0, 1'b0, '0);
        add_row(OP_STORE, 32'h0F0F_F0F0, 4'h4, 1'b1, 1'b0, '0);
        add_row(OP_RSVD7, 32'h0000_0000, 4'h0, 1'b0, 1'b1,
                gold_resp(CODE_IM, 1'b1, 1'b0, 1'b0, 32'h0));
        add_row(OP_DATA,  32'hFFFF_0000, 4'h7, 1'b1, 1'b0, '0);
        add_row(OP_LOAD,  32'h0000_FFFF, 4'h9, 1'b0, 1'b0, '0);
        add_row(OP_GETS,  32'h3333_CCCC, 4'hC, 1'b0, 1'b0, '0);
        add_row(OP_GETM,  32'hCCCC_3333, 4'h6, 1'b1, 1'b0, '0);
        add_row(OP_LOAD,  32'h1111_EEEE, 4'hB, 1'b0, 1'b0, '0);
        add_row(OP_DATA,  32'h1111_EEEE, 4'hD, 1'b0, 1'b0, '0);
        add_row(OP_GETS,  32'h2468_ACE0, 4'hE, 1'b0, 1'b0, '0);
        add_row(OP_STORE, 32'h1357_9BDF, 4'h2, 1'b1, 1'b0, '0);
        add_row(OP_GETM,  32'hFEDC_BA98, 4'hF, 1'b0, 1'b0, '0);
        add_row(OP_RSVD6, 32'hFFFF_FFFF, 4'hF, 1'b1, 1'b1,
                gold_resp(CODE_FFM, 1'b1, 1'b0, 1'b0, 32'h0));
        add_row(OP_DATA,  32'h89AB_CDEF, 4'h3, 1'b0, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 15;
        foreach (dir_tbl[k]) send_word(dir_tbl[k]);

        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n % 64 == 0) src_idle_pct = pick_idle_pct();
            // sink holds off while words keep coming, so the block backs up
            if (n % 200 == 100) begin
                hold_reqs   <= hold_reqs + 1;
                src_idle_pct = 0;
            end
            // let the pipe run dry before going on
            if (n % 200 == 180) begin
                in_if.valid <= 1'b0;
                do @(posedge i_clk); while (pending_resp.size() != 0);
            end
            pick_word(r);
            send_word(r);
        end
        in_if.valid <= 1'b0;

        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_bad == 0) begin
            $display("[moesif_line_coherence_fsm] OK");
        end else begin
            $display("[moesif_line_coherence_fsm] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/mlcf_pkg.sv
sv/mlcf_in_if.sv
sv/mlcf_out_if.sv
sv/mlcf_decode.sv
sv/moesif_line_coherence_fsm.sv
tb/tb.sv
